### rtl/fbrx_pkg.sv
// Shared types and constants of the framed byte receiver.
// Used by the parser, the result queue, the output stage and the top level.
package fbrx_pkg;

    localparam int BYTE_W      = 8;
    localparam int OUT_COUNT_W = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'h02;
    localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'h03;

    typedef enum logic {
        REG_START_MARKER = 1'b0,
        REG_END_MARKER   = 1'b1
    } t_reg_index;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_GOOD      = 2'd1,
        KIND_BAD_CHECK = 2'd2,
        KIND_BAD_END   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [BYTE_W-1:0]      payload_byte;
        logic [BYTE_W-1:0]      length_field;
        logic                   send_ack;
        logic [OUT_COUNT_W-1:0] good_frames;
        logic [OUT_COUNT_W-1:0] bad_frames;
    } t_result;

endpackage

### rtl/fbrx_front.sv
// Frame parser: accepts one byte per cycle while the queue is not full, tracks the frame phase
// and checksum, and pushes result records into the queue. Depends on fbrx_pkg.
module fbrx_front
    import fbrx_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_cfg_we,
    input  t_reg_index        i_cfg_index,
    input  logic [BYTE_W-1:0] i_cfg_data,
    input  logic              i_full,
    output logic              o_push,
    output t_result           o_result
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_DATA,
        PH_CHECK,
        PH_END
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [BYTE_W-1:0]      r_start, r_end;
    logic [BYTE_W-1:0]      r_len, n_len;
    logic [BYTE_W-1:0]      r_seen, n_seen;
    logic [BYTE_W-1:0]      r_xor, n_xor;
    logic [COUNT_WIDTH-1:0] r_good, n_good;
    logic [COUNT_WIDTH-1:0] r_bad, n_bad;
    logic                   accept;
    logic                   emit;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept && emit;

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_seen   = r_seen;
        n_xor    = r_xor;
        n_good   = r_good;
        n_bad    = r_bad;
        emit     = 1'b0;
        o_result = '0;
        o_result.kind = KIND_PAYLOAD;
        case (r_phase)
            PH_HUNT: begin
                if (i_data_byte == r_start) begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_len   = i_data_byte;
                n_seen  = '0;
                n_xor   = '0;
                n_phase = (i_data_byte == '0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
                n_xor  = r_xor ^ i_data_byte;
                n_seen = r_seen + 1'b1;
                if (n_seen >= r_len) begin
                    n_phase = PH_CHECK;
                end
                emit = 1'b1;
                o_result.kind         = KIND_PAYLOAD;
                o_result.payload_byte = i_data_byte;
            end
            PH_CHECK: begin
                if (i_data_byte != r_xor) begin
                    n_bad   = r_bad + 1'b1;
                    n_phase = PH_HUNT;
                    emit    = 1'b1;
                    o_result.kind = KIND_BAD_CHECK;
                end else begin
                    n_phase = PH_END;
                end
            end
            PH_END: begin
                n_phase = PH_HUNT;
                emit    = 1'b1;
                if (i_data_byte != r_end) begin
                    n_bad = r_bad + 1'b1;
                    o_result.kind = KIND_BAD_END;
                end else begin
                    n_good = r_good + 1'b1;
                    o_result.kind     = KIND_GOOD;
                    o_result.send_ack = 1'b1;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
        o_result.length_field = r_len;
        o_result.good_frames  = OUT_COUNT_W'(n_good);
        o_result.bad_frames   = OUT_COUNT_W'(n_bad);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_start <= START_MARKER_RESET;
            r_end   <= END_MARKER_RESET;
            r_len   <= '0;
            r_seen  <= '0;
            r_xor   <= '0;
            r_good  <= '0;
            r_bad   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_START_MARKER: r_start <= i_cfg_data;
                    REG_END_MARKER:   r_end   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_phase <= n_phase;
                r_len   <= n_len;
                r_seen  <= n_seen;
                r_xor   <= n_xor;
                r_good  <= n_good;
                r_bad   <= n_bad;
            end
        end
    end

endmodule

### rtl/fbrx_queue.sv
// Short result queue between the parser and the output stage.
// Depends on fbrx_pkg for the record type and depth.
module fbrx_queue
    import fbrx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_pop,
    output t_result o_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_result          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/fbrx_back.sv
// Output stage: moves records from the queue into the output register
// and holds them while the consumer stalls. Depends on fbrx_pkg.
module fbrx_back
    import fbrx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_data,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    logic    r_valid;
    t_result r_data;

    assign o_pop   = i_valid && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_data;
        end
    end

endmodule

### rtl/framed_byte_receiver_xor_check.sv
// Framed byte receiver with XOR checksum: start marker, length, payload, checksum, end marker.
// Throughput is one byte per cycle; the input stalls only once the consumer has held off
// long enough to fill the four-entry result queue behind the output register.
// A result is written into the result queue when its byte is accepted and is then moved into
// the output register, from which the consumer takes it; the queue has no bypass path.
// Synchronous active-low reset returns the parser to hunting, clears the counters
// and restores the start and end markers to 0x02 and 0x03.
module framed_byte_receiver_xor_check
    import fbrx_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [BYTE_W-1:0]      i_data_byte,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [1:0]             o_kind,
    output logic [BYTE_W-1:0]      o_payload_byte,
    output logic [BYTE_W-1:0]      o_length_field,
    output logic                   o_send_ack,
    output logic [OUT_COUNT_W-1:0] o_good_frames,
    output logic [OUT_COUNT_W-1:0] o_bad_frames,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [BYTE_W-1:0]      i_cfg_data
);

    logic    push, full, q_valid, pop;
    t_result front_res, q_res, out_res;

    fbrx_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (t_reg_index'(i_cfg_index)),
        .i_cfg_data  (i_cfg_data),
        .i_full      (full),
        .o_push      (push),
        .o_result    (front_res)
    );

    fbrx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_res),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_data  (q_res)
    );

    fbrx_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_data  (q_res),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_res)
    );

    assign o_kind         = out_res.kind;
    assign o_payload_byte = out_res.payload_byte;
    assign o_length_field = out_res.length_field;
    assign o_send_ack     = out_res.send_ack;
    assign o_good_frames  = out_res.good_frames;
    assign o_bad_frames   = out_res.bad_frames;

endmodule
